FILE: hdl/crsr_pkg.sv
package crsr_pkg;

    // Operation codes carried by the command port.
    typedef enum logic [1:0] {
        CMD_SQRT  = 2'd0,
        CMD_RSQRT = 2'd1,
        CMD_PAIR  = 2'd2,
        CMD_ISQRT = 2'd3
    } t_cmd;

    // Pipeline geometry.
    localparam int DIV_BITS    = 4;
    localparam int QUO_W       = 112;
    localparam int DIV_STAGES  = QUO_W / DIV_BITS;
    localparam int DREM_W      = 54;
    localparam int MANT_W      = 53;
    localparam int ROOT_BITS   = 2;
    localparam int ROOT_W      = 64;
    localparam int ROOT_STAGES = ROOT_W / ROOT_BITS;
    localparam int RAD_W       = 128;
    localparam int RREM_W      = 67;
    localparam int EXP_W       = 13;

    // Binary64 constants.
    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
    localparam logic [63:0] QNAN_BITS    = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] PINF_BITS    = 64'h7FF0_0000_0000_0000;
    localparam logic signed [EXP_W-1:0] SUBNORM_EXP = -13'sd1074;
    localparam logic signed [EXP_W-1:0] EXP_BIAS_INT = 13'sd1075;
    localparam logic [6:0]  SQRT_NORM    = 7'd109;
    localparam logic [7:0]  RSQRT_NORM   = 8'd107;
    localparam logic [5:0]  MANT_LEN     = 6'd53;
    localparam logic [DREM_W-1:0] DREM_INIT = DREM_W'(1) << 49;
    localparam logic [MANT_W-1:0] MANT_ONE  = MANT_W'(1) << 52;

    // Control fields that travel with every transaction.
    typedef struct packed {
        t_cmd                     cmd;
        logic                     spec;
        logic [63:0]              sres;
        logic                     sstat;
        logic                     exact;
        logic                     adj;
        logic signed [EXP_W-1:0]  half;
    } t_ctl;

    // Divider stage contents.
    typedef struct packed {
        t_ctl                ctl;
        logic [RAD_W-1:0]    rad;
        logic [DREM_W-1:0]   drem;
        logic [QUO_W-1:0]    q;
        logic [MANT_W-1:0]   dvs;
    } t_div;

    // Root stage contents.
    typedef struct packed {
        t_ctl                ctl;
        logic [RAD_W-1:0]    rad;
        logic [RREM_W-1:0]   rrem;
        logic [ROOT_W-1:0]   root;
    } t_rt;

    // Number of significant bits of a mantissa.
    function automatic logic [5:0] bit_len(input logic [MANT_W-1:0] m);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < MANT_W; i++) begin
            if (m[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

    // Several restoring steps of the reciprocal divider.
    function automatic t_div div_stage(input t_div d);
        t_div o;
        o = d;
        for (int i = 0; i < DIV_BITS; i++) begin
            if (o.drem >= {1'b0, o.dvs}) begin
                o.drem = o.drem - {1'b0, o.dvs};
                o.q    = {o.q[QUO_W-2:0], 1'b1};
            end else begin
                o.q    = {o.q[QUO_W-2:0], 1'b0};
            end
            o.drem = {o.drem[DREM_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // Several digit steps of the integer square root.
    function automatic t_rt root_stage(input t_rt d);
        t_rt               o;
        logic [RREM_W-1:0] cur;
        logic [RREM_W-1:0] trial;
        o = d;
        for (int i = 0; i < ROOT_BITS; i++) begin
            cur   = {o.rrem[RREM_W-3:0], o.rad[RAD_W-1:RAD_W-2]};
            trial = {1'b0, o.root, 2'b01};
            o.rad = {o.rad[RAD_W-3:0], 2'b00};
            if (cur >= trial) begin
                o.rrem = cur - trial;
                o.root = {o.root[ROOT_W-2:0], 1'b1};
            end else begin
                o.rrem = cur;
                o.root = {o.root[ROOT_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

endpackage

FILE: hdl/correctly_rounded_sqrt_rsqrt_unit.sv
// Channel   | Signals                                              | Handshake
// ----------+------------------------------------------------------+-------------------------
// command   | i_cmd, i_x_bits, i_radicand_hi, i_radicand_lo        | start high, busy low
// result    | o_result_bits, o_pair_root, o_pair_exp, o_status     | o_done strobe, one cycle
//
// One transaction is accepted every cycle; busy is never raised.
// Each result passes through decode, normalise, 28 reciprocal
// divider stages of four quotient bits, a root entry stage, 32 root stages of two
// root bits, the sticky stage and the rounding stage that drives the outputs.
// A synchronous active-low reset clears all valid bits; data registers are not reset.
// Results leave in command order and cannot be stalled by the receiver.
module correctly_rounded_sqrt_rsqrt_unit
    import crsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [63:0]        i_x_bits,
    input  logic [63:0]        i_radicand_hi,
    input  logic [63:0]        i_radicand_lo,
    output logic               o_done,
    output logic [63:0]        o_result_bits,
    output logic [63:0]        o_pair_root,
    output logic signed [11:0] o_pair_exp,
    output logic               o_status
);

    // The pipeline never stalls.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: classify the operand and find the mantissa length.
    // ------------------------------------------------------------------
    logic                    r1_vld;
    t_cmd                    r1_cmd;
    logic                    r1_spec;
    logic [63:0]             r1_sres;
    logic                    r1_sstat;
    logic [MANT_W-1:0]       r1_mant;
    logic signed [EXP_W-1:0] r1_e;
    logic [5:0]              r1_bn;
    logic [RAD_W-1:0]        r1_rad;

    logic [10:0]             n_raw;
    logic [51:0]             n_frac;
    logic                    n_neg;
    logic                    n_nan;
    logic                    n_inf;
    logic                    n_zero;
    logic [MANT_W-1:0]       n_mant;
    logic                    n_spec;
    logic [63:0]             n_sres;
    logic                    n_sstat;

    // Operand classification and special results.
    always_comb begin
        n_raw   = i_x_bits[62:52];
        n_frac  = i_x_bits[51:0];
        n_neg   = i_x_bits[63];
        n_nan   = (n_raw == EXP_ALL_ONES) && (n_frac != '0);
        n_inf   = (n_raw == EXP_ALL_ONES) && (n_frac == '0);
        n_zero  = (n_raw == '0) && (n_frac == '0);
        n_mant  = (n_raw == '0) ? {1'b0, n_frac} : {1'b1, n_frac};
        n_spec  = 1'b0;
        n_sres  = '0;
        n_sstat = 1'b0;
        case (t_cmd'(i_cmd))
            CMD_SQRT: begin
                if (n_nan) begin
                    n_spec = 1'b1; n_sres = i_x_bits; n_sstat = 1'b1;
                end else if (n_zero) begin
                    n_spec = 1'b1;
                end else if (n_neg) begin
                    n_spec = 1'b1; n_sres = QNAN_BITS; n_sstat = 1'b1;
                end else if (n_inf) begin
                    n_spec = 1'b1; n_sres = PINF_BITS;
                end
            end
            CMD_RSQRT: begin
                if (n_nan || n_zero || n_neg || n_inf) begin
                    n_spec = 1'b1; n_sstat = 1'b1;
                end
            end
            CMD_PAIR: begin
                if (n_nan || n_inf || (n_neg && !n_zero)) begin
                    n_spec = 1'b1; n_sstat = 1'b1;
                end else if (n_zero) begin
                    n_spec = 1'b1;
                end
            end
            default: begin
                n_spec = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_cmd   <= t_cmd'(i_cmd);
        r1_spec  <= n_spec;
        r1_sres  <= n_sres;
        r1_sstat <= n_sstat;
        r1_mant  <= n_mant;
        r1_e     <= (n_raw == '0) ? SUBNORM_EXP
                                  : $signed({2'b00, n_raw}) - EXP_BIAS_INT;
        r1_bn    <= bit_len(n_mant);
        r1_rad   <= {i_radicand_hi, i_radicand_lo};
    end

    // ------------------------------------------------------------------
    // Stage 2: normalise the radicand or the divisor, pin exponent parity.
    // ------------------------------------------------------------------
    logic [DIV_STAGES:0] r_dv_vld;
    t_div                r_dv [DIV_STAGES+1];
    t_div                n_dv0;

    logic [6:0]              n_sq_s0;
    logic [6:0]              n_sq_s;
    logic signed [EXP_W-1:0] n_sq_diff;
    logic [7:0]              n_rs_s0;
    logic [7:0]              n_rs_s;
    logic signed [EXP_W-1:0] n_rs_diff;
    logic                    n_sq_par;
    logic                    n_rs_par;

    always_comb begin
        // Square root: radicand mant * 2^s of 108 or 109 bits.
        n_sq_s0   = SQRT_NORM - {1'b0, r1_bn};
        n_sq_par  = r1_e[0] ^ n_sq_s0[0];
        n_sq_s    = n_sq_s0 - {6'd0, n_sq_par};
        n_sq_diff = r1_e - $signed({6'd0, n_sq_s});
        // Reciprocal root: quotient 2^s / mant, s pinned the same way.
        n_rs_s0   = RSQRT_NORM + {2'b00, r1_bn};
        n_rs_par  = r1_e[0] ^ n_rs_s0[0];
        n_rs_s    = n_rs_s0 - {7'd0, n_rs_par};
        n_rs_diff = -r1_e - $signed({5'd0, n_rs_s});

        n_dv0.ctl.cmd   = r1_cmd;
        n_dv0.ctl.spec  = r1_spec;
        n_dv0.ctl.sres  = r1_sres;
        n_dv0.ctl.sstat = r1_sstat;
        n_dv0.ctl.adj   = n_rs_par;
        n_dv0.dvs       = r1_mant << (MANT_LEN - r1_bn);
        n_dv0.ctl.exact = (n_dv0.dvs == MANT_ONE);
        n_dv0.drem      = DREM_INIT;
        n_dv0.q         = '0;
        case (r1_cmd)
            CMD_RSQRT: begin
                n_dv0.ctl.half = n_rs_diff >>> 1;
                n_dv0.rad      = '0;
            end
            CMD_ISQRT: begin
                n_dv0.ctl.half = '0;
                n_dv0.rad      = r1_rad;
            end
            default: begin
                n_dv0.ctl.half = n_sq_diff >>> 1;
                n_dv0.rad      = {{(RAD_W-MANT_W){1'b0}}, r1_mant} << n_sq_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= '0;
        end else begin
            r_dv_vld <= {r_dv_vld[DIV_STAGES-1:0], r1_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv[0] <= n_dv0;
    end

    // ------------------------------------------------------------------
    // Divider stages: floor(2^160 / divisor), four quotient bits a stage.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            r_dv[g+1] <= div_stage(r_dv[g]);
        end
    end

    // ------------------------------------------------------------------
    // Root entry: the reciprocal root takes the quotient as its radicand.
    // ------------------------------------------------------------------
    logic [ROOT_STAGES:0] r_rt_vld;
    t_rt                  r_rt [ROOT_STAGES+1];
    t_rt                  n_rt0;

    always_comb begin
        n_rt0.ctl  = r_dv[DIV_STAGES].ctl;
        n_rt0.rrem = '0;
        n_rt0.root = '0;
        if (r_dv[DIV_STAGES].ctl.cmd == CMD_RSQRT) begin
            n_rt0.rad = r_dv[DIV_STAGES].ctl.adj ? {17'd0, r_dv[DIV_STAGES].q[QUO_W-1:1]}
                                                 : {16'd0, r_dv[DIV_STAGES].q};
        end else begin
            n_rt0.rad = r_dv[DIV_STAGES].rad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_vld <= '0;
        end else begin
            r_rt_vld <= {r_rt_vld[ROOT_STAGES-1:0], r_dv_vld[DIV_STAGES]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rt[0] <= n_rt0;
    end

    // ------------------------------------------------------------------
    // Root stages: two root bits a stage.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
        always_ff @(posedge i_clk) begin
            r_rt[g+1] <= root_stage(r_rt[g]);
        end
    end

    // ------------------------------------------------------------------
    // Sticky stage: an inexact root becomes 2r + 1 one exponent lower.
    // ------------------------------------------------------------------
    logic                    r_f1_vld;
    t_ctl                    r_f1_ctl;
    logic [ROOT_W-1:0]       r_f1_pr;
    logic signed [EXP_W-1:0] r_f1_pe;
    logic [ROOT_W-1:0]       r_f1_root;
    logic                    n_f1_exact;

    always_comb begin
        n_f1_exact = (r_rt[ROOT_STAGES].rrem == '0) &&
                     ((r_rt[ROOT_STAGES].ctl.cmd != CMD_RSQRT) ||
                      r_rt[ROOT_STAGES].ctl.exact);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else begin
            r_f1_vld <= r_rt_vld[ROOT_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_ctl  <= r_rt[ROOT_STAGES].ctl;
        r_f1_root <= r_rt[ROOT_STAGES].root;
        if (n_f1_exact) begin
            r_f1_pr <= r_rt[ROOT_STAGES].root;
            r_f1_pe <= r_rt[ROOT_STAGES].ctl.half;
        end else begin
            r_f1_pr <= {r_rt[ROOT_STAGES].root[ROOT_W-2:0], 1'b1};
            r_f1_pe <= r_rt[ROOT_STAGES].ctl.half - 13'sd1;
        end
    end

    // ------------------------------------------------------------------
    // Rounding stage: nearest-even to 53 bits, then select the outputs.
    // ------------------------------------------------------------------
    logic [1:0]              n_k;
    logic [53:0]             n_m;
    logic                    n_inc;
    logic [53:0]             n_m1;
    logic signed [EXP_W-1:0] n_p;
    logic [51:0]             n_frac_out;
    logic [63:0]             n_rnd;
    logic [63:0]             n_res_bits;
    logic [63:0]             n_proot;
    logic signed [11:0]      n_pexp;
    logic                    n_stat;

    // The sticky root has 54 to 56 bits, so one to three bits are dropped.
    always_comb begin
        if (r_f1_pr[55]) begin
            n_k = 2'd3;
        end else if (r_f1_pr[54]) begin
            n_k = 2'd2;
        end else begin
            n_k = 2'd1;
        end
        case (n_k)
            2'd3: begin
                n_m   = r_f1_pr[56:3];
                n_inc = r_f1_pr[2] && ((r_f1_pr[1:0] != '0) || r_f1_pr[3]);
            end
            2'd2: begin
                n_m   = r_f1_pr[55:2];
                n_inc = r_f1_pr[1] && (r_f1_pr[0] || r_f1_pr[2]);
            end
            default: begin
                n_m   = r_f1_pr[54:1];
                n_inc = r_f1_pr[0] && r_f1_pr[1];
            end
        endcase
        n_m1 = n_m + {53'd0, n_inc};
        n_p  = r_f1_pe + $signed({11'd0, n_k}) + EXP_BIAS_INT;
        if (n_m1[53]) begin
            n_frac_out = n_m1[52:1];
            n_p        = n_p + 13'sd1;
        end else begin
            n_frac_out = n_m1[51:0];
        end
        n_rnd = {1'b0, n_p[10:0], n_frac_out};
    end

    // Output selection; fields that mean nothing for a command stay zero.
    always_comb begin
        n_res_bits = '0;
        n_proot    = '0;
        n_pexp     = '0;
        n_stat     = 1'b0;
        if (r_f1_ctl.spec) begin
            n_res_bits = r_f1_ctl.sres;
            n_stat     = r_f1_ctl.sstat;
        end else begin
            case (r_f1_ctl.cmd)
                CMD_SQRT, CMD_RSQRT: begin
                    n_res_bits = n_rnd;
                end
                CMD_PAIR: begin
                    n_proot = r_f1_pr;
                    n_pexp  = r_f1_pe[11:0];
                end
                default: begin
                    n_proot = r_f1_root;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result_bits <= n_res_bits;
        o_pair_root   <= n_proot;
        o_pair_exp    <= n_pexp;
        o_status      <= n_stat;
    end

endmodule

FILE: bench/crsr_checker.sv
module crsr_checker
    import crsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [63:0]        i_x_bits,
    input  logic [63:0]        i_radicand_hi,
    input  logic [63:0]        i_radicand_lo,
    input  logic               o_done,
    input  logic [63:0]        o_result_bits,
    input  logic [63:0]        o_pair_root,
    input  logic signed [11:0] o_pair_exp,
    input  logic               o_status,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] res;
        logic [63:0] proot;
        logic [11:0] pexp;
        logic        status;
    } t_answer;

    localparam int NORM = 108;

    t_answer answers_due[$];

    // Number of significant bits of a value.
    function automatic int sig_bits(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    // Floor square root of a 128-bit value, with an exactness flag.
    function automatic logic [63:0] floor_root(input logic [127:0] rad, output bit exact);
        logic [129:0] rem;
        logic [129:0] trial;
        logic [63:0]  r;
        rem = '0;
        r   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = {rem[127:0], rad[2*i+1 -: 2]};
            trial = {64'd0, r, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                r   = {r[62:0], 1'b1};
            end else begin
                r = {r[62:0], 1'b0};
            end
        end
        exact = (rem == 0);
        return r;
    endfunction

    // Sticky root of a scaled radicand: exact only if both division and root are.
    function automatic void sticky_root(input logic [127:0] rad, input bit div_exact,
                                        input int e0, input int s,
                                        output logic [63:0] root, output int pexp);
        bit          sq;
        logic [63:0] r;
        r = floor_root(rad, sq);
        if (div_exact && sq) begin
            root = r;
            pexp = (e0 - s) / 2;
        end else begin
            root = {r[62:0], 1'b1};
            pexp = (e0 - s) / 2 - 1;
        end
    endfunction

    // Root of mant * 2^e, scaled so the radicand has an even exponent.
    function automatic void root_of_value(input logic [63:0] mant, input int e,
                                          output logic [63:0] root, output int pexp);
        int           s;
        logic [127:0] rad;
        s = NORM - (sig_bits(mant) - 1);
        if (((e - s) & 1) != 0) begin
            s = s - 1;
        end
        rad = {64'd0, mant} << s;
        sticky_root(rad, 1'b1, e, s, root, pexp);
    endfunction

    // Root of 2^-e / mant via an exact long division.
    function automatic void root_of_recip(input logic [63:0] mant, input int e,
                                          output logic [63:0] root, output int pexp);
        int           s;
        logic [127:0] quo;
        logic [64:0]  rem;
        s = NORM - (1 - sig_bits(mant));
        if (((-e - s) & 1) != 0) begin
            s = s - 1;
        end
        quo = '0;
        rem = '0;
        for (int i = s; i >= 0; i--) begin
            rem = {rem[63:0], (i == s) ? 1'b1 : 1'b0};
            quo = {quo[126:0], 1'b0};
            if (rem >= {1'b0, mant}) begin
                rem    = rem - {1'b0, mant};
                quo[0] = 1'b1;
            end
        end
        sticky_root(quo, rem == 0, -e, s, root, pexp);
    endfunction

    // Nearest-even rounding of root * 2^p to a normal binary64.
    function automatic logic [63:0] round_to_double(input logic [63:0] root, input int p);
        int          bl;
        int          k;
        logic [63:0] m;
        logic [63:0] low;
        logic [63:0] half;
        logic [10:0] bexp;
        bl   = sig_bits(root);
        k    = (bl > 53) ? bl - 53 : 1;
        m    = root >> k;
        low  = root & ((64'd1 << k) - 1);
        half = 64'd1 << (k - 1);
        if (low > half || (low == half && m[0])) begin
            m = m + 1;
        end
        if (m[53]) begin
            m = m >> 1;
            p = p + 1;
        end
        p    = p + k;
        bexp = 11'(p + 52 + 1023);
        return {1'b0, bexp, m[51:0]};
    endfunction

    // Expected answer of one command.
    function automatic t_answer predict_root(input t_cmd cmd, input logic [63:0] x,
                                             input logic [63:0] hi, input logic [63:0] lo);
        t_answer     a;
        logic [10:0] raw;
        logic [51:0] frac;
        bit          neg, is_nan, is_inf, is_zero;
        logic [63:0] mant;
        int          e;
        logic [63:0] r;
        int          p;
        bit          sq;
        a      = '{default: '0};
        raw    = x[62:52];
        frac   = x[51:0];
        neg    = x[63];
        is_nan = (raw == EXP_ALL_ONES) && (frac != 0);
        is_inf = (raw == EXP_ALL_ONES) && (frac == 0);
        is_zero = (raw == 0) && (frac == 0);
        mant   = (raw == 0) ? {12'd0, frac} : {11'd0, 1'b1, frac};
        e      = (raw == 0) ? -1074 : int'(raw) - 1075;
        p      = 0;
        case (cmd)
            CMD_SQRT: begin
                if (is_nan) begin
                    a.res = x;
                    a.status = 1'b1;
                end else if (is_zero) begin
                    a.res = '0;
                end else if (neg) begin
                    a.res = QNAN_BITS;
                    a.status = 1'b1;
                end else if (is_inf) begin
                    a.res = PINF_BITS;
                end else begin
                    root_of_value(mant, e, r, p);
                    a.res = round_to_double(r, p);
                end
            end
            CMD_RSQRT: begin
                if (is_nan || is_zero || neg || is_inf) begin
                    a.status = 1'b1;
                end else begin
                    root_of_recip(mant, e, r, p);
                    a.res = round_to_double(r, p);
                end
            end
            CMD_PAIR: begin
                if (is_nan || is_inf || (neg && !is_zero)) begin
                    a.status = 1'b1;
                end else if (!is_zero) begin
                    root_of_value(mant, e, r, p);
                    a.proot = r;
                    a.pexp  = 12'(p);
                end
            end
            default: begin
                a.proot = floor_root({hi, lo}, sq);
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    assign pending = answers_due.size();

    initial fail_count = 0;

    // Predict on each accepted command, compare on each strobed result.
    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && o_done) begin
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result", o_result_bits, 64'd0);
            end else begin
                w = answers_due.pop_front();
                if (o_result_bits !== w.res) begin
                    report_mismatch("result_bits", o_result_bits, w.res);
                end
                if (o_pair_root !== w.proot) begin
                    report_mismatch("pair_root", o_pair_root, w.proot);
                end
                if (o_pair_exp !== w.pexp) begin
                    report_mismatch("pair_exp", 64'(o_pair_exp), 64'(w.pexp));
                end
                if (o_status !== w.status) begin
                    report_mismatch("status", 64'(o_status), 64'(w.status));
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            answers_due.push_back(predict_root(t_cmd'(i_cmd), i_x_bits,
                                               i_radicand_hi, i_radicand_lo));
        end
    end
endmodule

FILE: bench/tb_top.sv
module tb_top;
    import crsr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 65;
    localparam int CYCLE_CAP = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_cmd;
    logic [63:0]        i_x_bits;
    logic [63:0]        i_radicand_hi;
    logic [63:0]        i_radicand_lo;
    logic               o_done;
    logic [63:0]        o_result_bits;
    logic [63:0]        o_pair_root;
    logic signed [11:0] o_pair_exp;
    logic               o_status;
    int                 fail_count;
    int                 pending;
    int                 cycles;

    correctly_rounded_sqrt_rsqrt_unit uut (.*);

    crsr_checker checker_i (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout guard.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("correctly_rounded_sqrt_rsqrt_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A random double biased towards interesting classes.
    function automatic logic [63:0] pick_double();
        logic [63:0] x;
        x = rand64();
        case ($urandom_range(0, 9))
            0: x[62:52] = 11'd0;
            1: x[62:52] = EXP_ALL_ONES;
            2: x[51:0] = '0;
            3: x = {1'b0, 11'(1023 + 2 * $urandom_range(0, 26)), 52'd0}; // exact squares
            4: x[62:52] = 11'($urandom_range(1, 3));
            default: x[63] = ($urandom_range(0, 7) == 0);
        endcase
        return x;
    endfunction

    // Present one command and hold it until accepted.
    task automatic send_command(input t_cmd cmd, input logic [63:0] x,
                                input logic [63:0] hi, input logic [63:0] lo);
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_x_bits      <= x;
        i_radicand_hi <= hi;
        i_radicand_lo <= lo;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic send_op(input t_cmd cmd, input logic [63:0] x);
        send_command(cmd, x, rand64(), rand64());
    endtask

    initial begin
        logic [63:0] specials[14];
        int          burst;
        specials = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                     64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                     64'hFFF4_0000_0000_0000, 64'h0000_0000_0000_0001,
                     64'h000F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
                     64'h4010_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                     64'hBFF0_0000_0000_0000, 64'h4000_0000_0000_0000,
                     64'h0010_0000_0000_0000};
        start         = 1'b0;
        i_cmd         = CMD_SQRT;
        i_x_bits      = '0;
        i_radicand_hi = '0;
        i_radicand_lo = '0;
        i_rst_n       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: special operands for the three double commands.
        for (int i = 0; i < 14; i += 2) begin
            send_op(CMD_SQRT, specials[i]);
            send_op(CMD_RSQRT, specials[i + 1]);
            send_op(CMD_PAIR, specials[(i + 5) % 14]);
        end
        // Directed: integer root extremes.
        send_command(CMD_ISQRT, 64'd0, 64'd0, 64'd0);
        send_command(CMD_ISQRT, 64'd0, '1, '1);
        send_command(CMD_ISQRT, 64'd0, 64'd0, 64'd1);
        send_command(CMD_ISQRT, 64'd0, 64'd1, 64'd0);

        // Hold off until the pipeline has drained once.
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // Random part with bursts of back-to-back commands.
        for (int n = 0; n < 1250; n++) begin
            burst = $urandom_range(0, 3);
            if (burst == 3) begin
                send_command(CMD_ISQRT, rand64(), rand64() >> $urandom_range(0, 63),
                             rand64());
            end else begin
                send_op(t_cmd'(burst), pick_double());
            end
            if ((n % 200) >= 40) begin
                idle_gap();
            end
        end
        start <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("correctly_rounded_sqrt_rsqrt_unit: match");
        end else begin
            $display("correctly_rounded_sqrt_rsqrt_unit: mismatch");
        end
        $finish;
    end
endmodule
